// ===== hdl/sbv_pkg.sv =====
// Shared types and constants for the settings block validator.
`default_nettype none

package sbv_pkg;

  localparam int unsigned HEADER_OFFSET = 32'h000CA;
  localparam int unsigned SIZE_W = 17;
  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET = 17'h10000;
  localparam int unsigned POS_W = 17;
  localparam logic [31:0] MIN_LENGTH = 32'd8;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    STATUS_VALID     = 2'd0,
    STATUS_TOO_LONG  = 2'd1,
    STATUS_TOO_SHORT = 2'd2,
    STATUS_BAD_SUM   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_ACCUM,
    OP_REPORT,
    OP_FINISH
  } op_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] block_length;
  } out_item_t;

  typedef struct packed {
    op_kind_e    kind;
    status_e     status;
    logic        clear;
    logic [1:0]  lane;
    logic [7:0]  data_byte;
    logic [31:0] block_length;
  } op_t;

endpackage

`default_nettype wire

// ===== hdl/sbv_front.sv =====
// Front end: tracks block framing, reads the header and classifies each byte.
`default_nettype none

module sbv_front #(
  parameter int unsigned HeaderOffset = sbv_pkg::HEADER_OFFSET
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire sbv_pkg::in_item_t           in_item_i,
  output logic                             in_stall_o,
  input  wire logic                        cfg_valid_i,
  input  wire logic [sbv_pkg::SIZE_W-1:0]  cfg_data_i,
  output logic                             cfg_ready_o,
  input  wire logic                        queue_full_i,
  output logic                             op_valid_o,
  output sbv_pkg::op_t                     op_o
);
  import sbv_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_BODY
  } phase_e;

  phase_e              phase_q, phase_d, phase_cur;
  logic [POS_W-1:0]    pos_q, pos_d, pos_cur, pos_next;
  logic [31:0]         len_q, len_d, len_cur, len_hdr;
  logic [SIZE_W-1:0]   block_size_q;
  logic [32:0]         len_sum;
  logic                too_long;
  logic                accept;

  assign in_stall_o  = queue_full_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    accept    = in_valid_i && !queue_full_i;
    phase_cur = in_item_i.block_start ? PH_HEADER : phase_q;
    pos_cur   = in_item_i.block_start ? '0 : pos_q;
    len_cur   = in_item_i.block_start ? '0 : len_q;
    pos_next  = pos_cur + POS_W'(1);
    len_hdr   = (phase_cur == PH_HEADER) ? {len_cur[23:0], in_item_i.data_byte} : len_cur;
    len_sum   = {1'b0, len_hdr} + 33'(HeaderOffset);
    too_long  = len_sum > 33'(block_size_q);

    phase_d    = phase_q;
    pos_d      = pos_q;
    len_d      = len_q;
    op_valid_o = 1'b0;
    op_o.kind         = OP_ACCUM;
    op_o.status       = STATUS_VALID;
    op_o.clear        = in_item_i.block_start;
    op_o.lane         = pos_cur[1:0];
    op_o.data_byte    = in_item_i.data_byte;
    op_o.block_length = len_hdr;

    if (accept && phase_cur != PH_IDLE) begin
      op_valid_o = 1'b1;
      pos_d      = pos_next;
      len_d      = len_hdr;
      phase_d    = phase_cur;
      case (phase_cur)
        PH_HEADER: begin
          if (pos_cur == POS_W'(3)) begin
            if (too_long) begin
              op_o.kind   = OP_REPORT;
              op_o.status = STATUS_TOO_LONG;
              phase_d     = PH_IDLE;
            end else if (len_hdr < MIN_LENGTH) begin
              op_o.kind   = OP_REPORT;
              op_o.status = STATUS_TOO_SHORT;
              phase_d     = PH_IDLE;
            end else begin
              phase_d = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (32'(pos_next) == len_hdr) begin
            op_o.kind = OP_FINISH;
            phase_d   = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      pos_q        <= '0;
      len_q        <= '0;
      block_size_q <= BLOCK_SIZE_RESET;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      if (cfg_valid_i) begin
        block_size_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sbv_queue.sv =====
// Short first-in first-out queue of classified operations.
`default_nettype none

module sbv_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire sbv_pkg::op_t push_op_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              not_empty_o,
  output sbv_pkg::op_t      pop_op_o
);
  import sbv_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  op_t             slots_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o      = (count_q == CntW'(QUEUE_DEPTH));
  assign not_empty_o = (count_q != '0);
  assign pop_op_o    = slots_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sbv_back.sv =====
// Back end: assembles words, keeps the running sum and registers each result item.
`default_nettype none

module sbv_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           op_valid_i,
  input  wire sbv_pkg::op_t   op_i,
  output logic                op_pop_o,
  output logic                out_valid_o,
  output sbv_pkg::out_item_t  out_item_o,
  input  wire logic           out_stall_i
);
  import sbv_pkg::*;

  logic [31:0] wa_q, wa_d, sum_q, sum_d;
  logic [31:0] wa_base, sum_base, word, addend, total;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    op_pop_o = op_valid_i && (!out_valid_q || !out_stall_i);
    wa_base  = op_i.clear ? '0 : wa_q;
    sum_base = op_i.clear ? '0 : sum_q;
    word     = '0;
    case (op_i.lane)
      2'd0:    word = {16'd0, op_i.data_byte, 8'd0};
      2'd1:    word = (wa_base << 16) | {8'd0, op_i.data_byte, 16'd0};
      2'd2:    word = wa_base | {16'd0, op_i.data_byte, 8'd0};
      default: word = wa_base | {24'd0, op_i.data_byte};
    endcase
    // A completed word goes into the sum; otherwise the partial word only joins the total.
    addend = word;
    total  = sum_base + addend;
    if (op_i.lane == 2'd3) begin
      wa_d  = '0;
      sum_d = total;
    end else begin
      wa_d  = word;
      sum_d = sum_base;
    end

    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (op_pop_o && op_i.kind != OP_ACCUM) begin
      out_valid_d        = 1'b1;
      out_d.block_length = op_i.block_length;
      if (op_i.kind == OP_FINISH) begin
        out_d.status = (total == '1) ? STATUS_VALID : STATUS_BAD_SUM;
      end else begin
        out_d.status = op_i.status;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wa_q        <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (op_pop_o) begin
        wa_q  <= wa_d;
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

`default_nettype wire

// ===== hdl/settings_block_validator.sv =====
// Top level of the settings block validator: front end, operation queue and back end.
//
//   Channel | Direction | Handshake                | Payload
//   in      | input     | in_valid_i / in_stall_o  | in_item_i (data_byte, block_start)
//   out     | output    | out_valid_o / out_stall_i| out_item_o (status, block_length)
//   cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_data_i (block_size)
//
// One byte item is accepted per cycle while the two-entry operation queue has room.
// A result item for the byte that completes or rejects a block is first written into the
// operation queue and then loaded into the output register; the back end uses a single
// adder. Reset clears the framing state, the queue and the output valid flag, and sets
// the block size to 65536. A stalled output fills the queue and then stalls input.
`default_nettype none

module settings_block_validator #(
  parameter int unsigned HeaderOffset = sbv_pkg::HEADER_OFFSET
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire sbv_pkg::in_item_t           in_item_i,
  output logic                             in_stall_o,
  output logic                             out_valid_o,
  output sbv_pkg::out_item_t               out_item_o,
  input  wire logic                        out_stall_i,
  input  wire logic                        cfg_valid_i,
  input  wire logic [sbv_pkg::SIZE_W-1:0]  cfg_data_i,
  output logic                             cfg_ready_o
);
  import sbv_pkg::*;

  logic queue_full, push, pop, not_empty;
  op_t  push_op, pop_op;

  sbv_front #(
    .HeaderOffset(HeaderOffset)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .queue_full_i(queue_full),
    .op_valid_o  (push),
    .op_o        (push_op)
  );

  sbv_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_op_i  (push_op),
    .full_o     (queue_full),
    .pop_i      (pop),
    .not_empty_o(not_empty),
    .pop_op_o   (pop_op)
  );

  sbv_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (not_empty),
    .op_i       (pop_op),
    .op_pop_o   (pop),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .out_stall_i(out_stall_i)
  );

endmodule

`default_nettype wire
